// ----- hdl/mtoi_pkg.sv -----
// Shared types, widths and codes for the multichannel third-order IIR filter.
package mtoi_pkg;

  // Default number of channels that hold history.
  localparam int NUM_CHANNELS_DEF = 8;

  // Field widths.
  localparam int CH_W      = 3;
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 20;
  localparam int HIST_Y_W  = 34;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Datapath widths: products, partial sums, accumulator and its integer part.
  localparam int PX_W     = COEF_W + SAMPLE_W + 1;
  localparam int PY_W     = COEF_W + HIST_Y_W;
  localparam int SUM_FF_W = PX_W + 2;
  localparam int SUM_FB_W = PY_W + 2;
  localparam int ACC_W    = PY_W + 4;
  localparam int Q_W      = ACC_W - FRAC_W;

  // Request codes.
  typedef enum logic {
    REQ_FILTER = 1'b0,
    REQ_PRIME  = 1'b1
  } req_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B0 = 3'd0,
    CFG_B1 = 3'd1,
    CFG_B2 = 3'd2,
    CFG_B3 = 3'd3,
    CFG_A1 = 3'd4,
    CFG_A2 = 3'd5,
    CFG_A3 = 3'd6
  } cfg_idx_t;

  // One channel's history as stored in memory; output terms are two's complement.
  typedef struct packed {
    logic [SAMPLE_W-1:0] x1;
    logic [SAMPLE_W-1:0] x2;
    logic [SAMPLE_W-1:0] x3;
    logic [HIST_Y_W-1:0] y1;
    logic [HIST_Y_W-1:0] y2;
    logic [HIST_Y_W-1:0] y3;
  } hist_t;

  // Control and sample carried along the pipeline.
  typedef struct packed {
    logic                vld;
    req_t                req;
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] x;
  } stage_t;

endpackage

// ----- hdl/mtoi_if.sv -----
// Valid/ready channel interfaces for the filter's input and result words.
interface mtoi_in_if
  import mtoi_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [CH_W-1:0]     channel;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output req_type, output channel, output sample, input ready);
  modport sink   (input valid, input req_type, input channel, input sample, output ready);
endinterface

interface mtoi_out_if
  import mtoi_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     out_channel;
  logic [SAMPLE_W-1:0] filtered;

  modport source (output valid, output out_channel, output filtered, input ready);
  modport sink   (input valid, input out_channel, input filtered, output ready);
endinterface

// ----- hdl/multichannel_third_order_iir.sv -----
// Multichannel third-order direct-form-I IIR filter with per-channel history in RAM.
//
// Input words (in_bus) carry a request type, a channel and a 16-bit sample. A filter
// request computes y = b0*x + b1*x1 + b2*x2 + b3*x3 - a1*y1 - a2*y2 - a3*y3 with
// Q4.16 coefficients, truncates toward zero, updates the channel's history and sends
// one result word (out_bus) with the channel and y clamped to 0..65535. A prime
// request loads x1 and y1..y3 with the sample and sends nothing. Words for channels
// at or above NUM_CHANNELS are accepted and dropped.
// The user writes coefficients through cfg_we/cfg_index/cfg_wdata only while the
// block is idle; the block does not enforce this. A result word is valid once it has
// passed stages 1 to 4 and the output register. Throughput: one word per cycle while
// the receiver takes results and no word names a channel still in the four-stage
// read-multiply-sum-writeback pipeline; such a word waits until that entry is
// written back, so one channel alone is not accepted again before it leaves stage 4.
// Reset clears the coefficients, the pipeline and one valid flag per channel; a
// channel without its flag reads as all-zero history, so no clearing pass is needed.
// When the receiver holds off a result, the whole pipeline holds and in_bus.ready
// drops; a waiting result never blocks acceptance if out_bus.ready is high.
module multichannel_third_order_iir
  import mtoi_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mtoi_in_if.sink              in_bus,
  mtoi_out_if.source           out_bus,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_wdata
);

  localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int HIST_W = $bits(hist_t);

  // Coefficient registers.
  logic signed [COEF_W-1:0] coef_b0_r, coef_b1_r, coef_b2_r, coef_b3_r;
  logic signed [COEF_W-1:0] coef_a1_r, coef_a2_r, coef_a3_r;

  // Pipeline control and payload.
  stage_t s1_r, s1_nxt, s2_r, s3_r, s4_r;
  hist_t  rd_hist, s2_hist_r, s3_hist_r, s4_hist_r, wr_hist;
  logic signed [PX_W-1:0]     px_r [4];
  logic signed [PX_W-1:0]     px_nxt [4];
  logic signed [PY_W-1:0]     py_r [3];
  logic signed [PY_W-1:0]     py_nxt [3];
  logic signed [SUM_FF_W-1:0] sum_ff_r, sum_ff_nxt;
  logic signed [SUM_FB_W-1:0] sum_fb_r, sum_fb_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;

  // Output stage.
  logic                       out_vld_r;
  logic [CH_W-1:0]            out_ch_r;
  logic [SAMPLE_W-1:0]        out_val_r;

  // Handshake and RAM control.
  logic                       adv, hazard, in_range, in_take;
  logic                       ram_re, ram_we;
  logic [ADDR_W-1:0]          ram_raddr, ram_waddr;
  logic [HIST_W-1:0]          ram_rdata;
  logic [NUM_CHANNELS-1:0]    ent_vld_r;
  logic                       rd_vld_r;

  // Result arithmetic.
  logic signed [Q_W-1:0]      y_trunc;
  logic [Q_W-HIST_Y_W:0]      y_top;
  logic [HIST_Y_W-1:0]        y_sat;
  logic [SAMPLE_W-1:0]        y_clamp;
  logic                       dup_ch;

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b0_r <= '0;
      coef_b1_r <= '0;
      coef_b2_r <= '0;
      coef_b3_r <= '0;
      coef_a1_r <= '0;
      coef_a2_r <= '0;
      coef_a3_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_B0:  coef_b0_r <= cfg_wdata;
        CFG_B1:  coef_b1_r <= cfg_wdata;
        CFG_B2:  coef_b2_r <= cfg_wdata;
        CFG_B3:  coef_b3_r <= cfg_wdata;
        CFG_A1:  coef_a1_r <= cfg_wdata;
        CFG_A2:  coef_a2_r <= cfg_wdata;
        CFG_A3:  coef_a3_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or being emptied.
  assign adv = !out_vld_r || out_bus.ready;

  // Interlock: a channel still in flight has not written its history back yet.
  assign hazard = (s1_r.vld && (s1_r.ch == in_bus.channel)) ||
                  (s2_r.vld && (s2_r.ch == in_bus.channel)) ||
                  (s3_r.vld && (s3_r.ch == in_bus.channel)) ||
                  (s4_r.vld && (s4_r.ch == in_bus.channel));

  assign in_bus.ready = adv && !hazard;
  assign in_take      = in_bus.valid && in_bus.ready;
  assign in_range     = 32'(in_bus.channel) < 32'(NUM_CHANNELS);

  // Stage 1 entry and history read.
  always_comb begin
    s1_nxt.vld = in_take && in_range;
    s1_nxt.req = req_t'(in_bus.req_type);
    s1_nxt.ch  = in_bus.channel;
    s1_nxt.x   = in_bus.sample;
  end

  assign ram_re    = s1_nxt.vld;
  assign ram_raddr = ADDR_W'(in_bus.channel);

  // A channel never written since reset reads as zero history.
  assign rd_hist = rd_vld_r ? hist_t'(ram_rdata) : '0;

  // Stage 1 to 2: the seven products.
  always_comb begin
    px_nxt[0] = coef_b0_r * $signed({1'b0, s1_r.x});
    px_nxt[1] = coef_b1_r * $signed({1'b0, rd_hist.x1});
    px_nxt[2] = coef_b2_r * $signed({1'b0, rd_hist.x2});
    px_nxt[3] = coef_b3_r * $signed({1'b0, rd_hist.x3});
    py_nxt[0] = coef_a1_r * $signed(rd_hist.y1);
    py_nxt[1] = coef_a2_r * $signed(rd_hist.y2);
    py_nxt[2] = coef_a3_r * $signed(rd_hist.y3);
  end

  // Stage 2 to 3: feedforward and feedback sums; stage 3 to 4: difference.
  assign sum_ff_nxt = SUM_FF_W'(px_r[0]) + SUM_FF_W'(px_r[1]) +
                      SUM_FF_W'(px_r[2]) + SUM_FF_W'(px_r[3]);
  assign sum_fb_nxt = SUM_FB_W'(py_r[0]) + SUM_FB_W'(py_r[1]) + SUM_FB_W'(py_r[2]);
  assign acc_nxt    = ACC_W'(sum_ff_r) - ACC_W'(sum_fb_r);

  // Stage 4: truncate toward zero, saturate to the history width, clamp the result.
  always_comb begin
    y_trunc = $signed(acc_r[ACC_W-1:FRAC_W]) +
              $signed({{(Q_W-1){1'b0}}, acc_r[ACC_W-1] && (|acc_r[FRAC_W-1:0])});
    y_top   = y_trunc[Q_W-1:HIST_Y_W-1];
    if ((&y_top) || !(|y_top)) begin
      y_sat = y_trunc[HIST_Y_W-1:0];
    end else if (y_trunc[Q_W-1]) begin
      y_sat = {1'b1, {(HIST_Y_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(HIST_Y_W-1){1'b1}}};
    end
    if (y_sat[HIST_Y_W-1]) begin
      y_clamp = '0;
    end else if (|y_sat[HIST_Y_W-2:SAMPLE_W]) begin
      y_clamp = '1;
    end else begin
      y_clamp = y_sat[SAMPLE_W-1:0];
    end
  end

  // Write-back word: shift the history, or prime it with the sample.
  always_comb begin
    case (s4_r.req)
      REQ_PRIME: begin
        wr_hist.x1 = s4_r.x;
        wr_hist.x2 = s4_hist_r.x2;
        wr_hist.x3 = s4_hist_r.x3;
        wr_hist.y1 = HIST_Y_W'(s4_r.x);
        wr_hist.y2 = HIST_Y_W'(s4_r.x);
        wr_hist.y3 = HIST_Y_W'(s4_r.x);
      end
      default: begin
        wr_hist.x1 = s4_r.x;
        wr_hist.x2 = s4_hist_r.x1;
        wr_hist.x3 = s4_hist_r.x2;
        wr_hist.y1 = y_sat;
        wr_hist.y2 = s4_hist_r.y1;
        wr_hist.y3 = s4_hist_r.y2;
      end
    endcase
  end

  assign ram_we    = adv && s4_r.vld;
  assign ram_waddr = ADDR_W'(s4_r.ch);

  // Pipeline control, output valid and per-channel written flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld  <= 1'b0;
      s2_r.vld  <= 1'b0;
      s3_r.vld  <= 1'b0;
      s4_r.vld  <= 1'b0;
      out_vld_r <= 1'b0;
      ent_vld_r <= '0;
    end else if (adv) begin
      s1_r      <= s1_nxt;
      s2_r      <= s1_r;
      s3_r      <= s2_r;
      s4_r      <= s3_r;
      out_vld_r <= s4_r.vld && (s4_r.req == REQ_FILTER);
      if (s4_r.vld) begin
        ent_vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_vld_r <= ent_vld_r[ram_raddr];
    end
    if (adv) begin
      px_r      <= px_nxt;
      py_r      <= py_nxt;
      s2_hist_r <= rd_hist;
      sum_ff_r  <= sum_ff_nxt;
      sum_fb_r  <= sum_fb_nxt;
      s3_hist_r <= s2_hist_r;
      acc_r     <= acc_nxt;
      s4_hist_r <= s3_hist_r;
      if (s4_r.vld && (s4_r.req == REQ_FILTER)) begin
        out_ch_r  <= s4_r.ch;
        out_val_r <= y_clamp;
      end
    end
  end

  // History memory.
  mtoi_ram #(
    .WIDTH (HIST_W),
    .DEPTH (NUM_CHANNELS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_hist),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result channel.
  assign out_bus.valid       = out_vld_r;
  assign out_bus.out_channel = out_ch_r;
  assign out_bus.filtered    = out_val_r;

  // Two stages in flight on one channel would mean the interlock failed.
  assign dup_ch = (s1_r.vld && s2_r.vld && (s1_r.ch == s2_r.ch)) ||
                  (s1_r.vld && s3_r.vld && (s1_r.ch == s3_r.ch)) ||
                  (s1_r.vld && s4_r.vld && (s1_r.ch == s4_r.ch)) ||
                  (s2_r.vld && s3_r.vld && (s2_r.ch == s3_r.ch)) ||
                  (s2_r.vld && s4_r.vld && (s2_r.ch == s4_r.ch)) ||
                  (s3_r.vld && s4_r.vld && (s3_r.ch == s4_r.ch));

  // No channel is in flight twice.
  assert property (@(posedge clk) disable iff (!rst_n) !dup_ch)
    else $error("two pipeline stages hold the same channel");

  // An accepted in-range word enters stage 1 with its channel.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_range) |=> (s1_r.vld && (s1_r.ch == $past(in_bus.channel))))
    else $error("accepted word did not enter the pipeline");

  // A result appears only after a filter request left stage 4.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s4_r.vld && (s4_r.req == REQ_FILTER)))
    else $error("result appeared without a filter request");

  // A held result stops intake.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_bus.ready) |-> !in_bus.ready)
    else $error("input accepted while the result is stalled");

endmodule

// ----- hdl/mtoi_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module mtoi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds when no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
